/* rtl/gehist_pkg.sv */
// ----------------------------------------------------------------------------
// Gated energy histogram package
// Field widths, register indexes, request/response payloads and the
// controller state type shared by the histogram modules.
// ----------------------------------------------------------------------------
package gehist_pkg;

    localparam int NUM_BINS_DEF   = 4096;
    localparam int COUNT_BITS_DEF = 32;

    localparam int ENERGY_W    = 16;
    localparam int SLICE_W     = 16;
    localparam int PROJ_W      = 8;
    localparam int SEL_W       = 12;
    localparam int OUT_COUNT_W = 32;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic REQ_EVENT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROJ_LOW   = 2'd0,
        CFG_PROJ_HIGH  = 2'd1,
        CFG_SLICE_LOW  = 2'd2,
        CFG_SLICE_HIGH = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic                req_type;
        logic [ENERGY_W-1:0] event_energy;
        logic [SLICE_W-1:0]  slice_number;
        logic [PROJ_W-1:0]   projection_number;
        logic [SEL_W-1:0]    bin_select;
    } t_req;

    typedef struct packed {
        logic                   accepted;
        logic [OUT_COUNT_W-1:0] bin_count;
        logic [ENERGY_W-1:0]    max_energy;
        logic                   data_error;
    } t_rsp;

endpackage

/* rtl/gehist_stream_if.sv */
// ----------------------------------------------------------------------------
// Gated energy histogram stream interface
// Valid/ready channel carrying one payload of type T per request.
// ----------------------------------------------------------------------------
interface gehist_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/gehist_cfg.sv */
// ----------------------------------------------------------------------------
// Gated energy histogram window registers
// Holds the projection and slice windows and checks an event against them.
// ----------------------------------------------------------------------------
module gehist_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gehist_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gehist_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [gehist_pkg::SLICE_W-1:0]    i_slice,
    input  logic [gehist_pkg::PROJ_W-1:0]     i_proj,
    output logic                            o_hit
);
    import gehist_pkg::*;

    logic [PROJ_W-1:0]  r_proj_low;
    logic [PROJ_W-1:0]  r_proj_high;
    logic [SLICE_W-1:0] r_slice_low;
    logic [SLICE_W-1:0] r_slice_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proj_low   <= '0;
            r_proj_high  <= '0;
            r_slice_low  <= SLICE_W'(64);
            r_slice_high <= SLICE_W'(64);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PROJ_LOW:   r_proj_low   <= i_cfg_data[PROJ_W-1:0];
                CFG_PROJ_HIGH:  r_proj_high  <= i_cfg_data[PROJ_W-1:0];
                CFG_SLICE_LOW:  r_slice_low  <= i_cfg_data[SLICE_W-1:0];
                CFG_SLICE_HIGH: r_slice_high <= i_cfg_data[SLICE_W-1:0];
            endcase
        end
    end

    // An empty window (low above high) rejects everything on its own.
    assign o_hit = (i_proj >= r_proj_low) && (i_proj <= r_proj_high) &&
                   (i_slice >= r_slice_low) && (i_slice <= r_slice_high);

endmodule

/* rtl/gehist_mem.sv */
// ----------------------------------------------------------------------------
// Gated energy histogram bin memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module gehist_mem #(
    parameter int DEPTH = gehist_pkg::NUM_BINS_DEF,
    parameter int WIDTH = gehist_pkg::COUNT_BITS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/gated_energy_histogram_core.sv */
// ----------------------------------------------------------------------------
// Gated energy histogram core
// Windowed multichannel-analyzer histogram with saturating bin counts,
// running peak energy and a sticky range error flag.
//
//   Channel   Dir  Carries
//   i_req     in   event (energy, slice, projection) or bin read request
//   o_rsp     out  accepted flag, bin count, peak energy, error flag
//   i_cfg_*   in   window register writes, index 0..3
//
// Each request reads its bin from memory when it is accepted and the updated
// count is written back in S_UPDATE, so at most one
// request is in the memory read-modify-write at a time.
// After reset the bin memory is cleared one entry per cycle, all NUM_BINS
// entries, while i_req.ready stays low; register writes are taken meanwhile.
// A response waiting in the output register does not block the next
// request; the write-back only stalls when a second response is due.
// ----------------------------------------------------------------------------
module gated_energy_histogram_core #(
    parameter int NUM_BINS   = gehist_pkg::NUM_BINS_DEF,
    parameter int COUNT_BITS = gehist_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gehist_stream_if.sink                     i_req,
    gehist_stream_if.source                   o_rsp,
    input  logic                              i_cfg_we,
    input  logic [gehist_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gehist_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gehist_pkg::*;

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam int WIDE_W = ENERGY_W + 1;
    localparam logic [WIDE_W-1:0] BINS_WIDE = WIDE_W'(NUM_BINS);

    t_state r_state;
    t_state n_state;

    logic [ADDR_W-1:0]     r_clr_addr;
    t_req                  r_req;
    logic                  r_hit;
    logic                  r_binned;
    logic                  r_sel_ok;
    logic [ADDR_W-1:0]     r_addr;
    logic [ENERGY_W-1:0]   r_peak;
    logic                  r_err;
    logic                  r_out_valid;
    t_rsp                  r_out;

    logic                  hit;
    logic                  req_fire;
    logic                  update_done;
    logic                  clear_last;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [COUNT_BITS-1:0] mem_rdata;
    logic [ADDR_W-1:0]     rd_addr;
    logic [WIDE_W-1:0]     energy_wide;
    logic [WIDE_W-1:0]     bin_wide;
    logic [WIDE_W-1:0]     sel_wide;
    logic                  energy_ok;
    logic [63:0]           count_wide;
    logic [OUT_COUNT_W-1:0] count_out;
    logic                  event_acc;
    logic [ENERGY_W-1:0]   n_peak;
    logic                  n_err;
    t_rsp                  n_out;

    gehist_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_slice   (i_req.data.slice_number),
        .i_proj    (i_req.data.projection_number),
        .o_hit     (hit)
    );

    gehist_mem #(
        .DEPTH(NUM_BINS),
        .WIDTH(COUNT_BITS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (req_fire),
        .i_raddr(rd_addr),
        .o_rdata(mem_rdata)
    );

    // Address decode for the incoming request.
    always_comb begin
        energy_wide = WIDE_W'(i_req.data.event_energy);
        bin_wide    = energy_wide - WIDE_W'(1);
        sel_wide    = WIDE_W'(i_req.data.bin_select);
        energy_ok   = (energy_wide != '0) && (energy_wide <= BINS_WIDE);
        if (i_req.data.req_type == REQ_READ) begin
            rd_addr = sel_wide[ADDR_W-1:0];
        end else begin
            rd_addr = bin_wide[ADDR_W-1:0];
        end
    end

    assign req_fire    = i_req.valid && i_req.ready;
    assign clear_last  = (r_clr_addr == ADDR_W'(NUM_BINS - 1));
    assign update_done = (r_state == S_UPDATE) && (!r_out_valid || o_rsp.ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (update_done) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // State outputs: input ready and memory write port.
    always_comb begin
        i_req.ready = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
            end
            S_UPDATE: begin
                mem_we = update_done && r_binned;
                if (mem_rdata != '1) begin
                    mem_wdata = mem_rdata + COUNT_BITS'(1);
                end else begin
                    mem_wdata = mem_rdata;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Response assembly from the registered request and read data.
    always_comb begin
        count_wide = 64'(mem_rdata);
        if (count_wide > 64'h0000_0000_FFFF_FFFF) begin
            count_out = '1;
        end else begin
            count_out = count_wide[OUT_COUNT_W-1:0];
        end
        event_acc = (r_req.req_type == REQ_EVENT) && r_hit;
        n_peak    = r_peak;
        n_err     = r_err;
        if (event_acc) begin
            if (r_req.event_energy > r_peak) n_peak = r_req.event_energy;
            if (!r_binned) n_err = 1'b1;
        end
        n_out.accepted   = event_acc;
        n_out.bin_count  = '0;
        if ((r_req.req_type == REQ_READ) && r_sel_ok) begin
            n_out.bin_count = count_out;
        end
        n_out.max_energy = n_peak;
        n_out.data_error = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_peak      <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (update_done) begin
                r_peak      <= n_peak;
                r_err       <= n_err;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_req    <= i_req.data;
            r_hit    <= hit;
            r_binned <= hit && (i_req.data.req_type == REQ_EVENT) && energy_ok;
            r_sel_ok <= sel_wide < BINS_WIDE;
            r_addr   <= rd_addr;
        end
        if (update_done) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    a_peak_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_peak >= $past(r_peak))
        else $error("peak energy decreased");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_err) |-> r_err)
        else $error("error flag cleared without reset");

    a_event_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.accepted |-> o_rsp.data.bin_count == '0)
        else $error("event response carries a bin count");

    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_state == S_UPDATE)
        else $error("accepted request did not enter update");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !mem_we)
        else $error("bin memory written while idle");

endmodule
